>>> hdl/brc_pkg.sv
// Shared constants, register codes and width helpers for the box/ramp contact unit.
`default_nettype none
package brc_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int EPS_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int QUEUE_DEPTH     = 2;
  localparam int EPS_RESET       = 7;
  localparam int FLOOR_MIN_UNITS = 20;
  localparam int FLOOR_MAX_UNITS = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EPSILON   = 2'd0,
    REG_FLOOR_MIN = 2'd1,
    REG_FLOOR_MAX = 2'd2
  } cfg_reg_t;

  // bits in one queued item, see item_t in the front and back
  function automatic int item_bits(input int cw);
    return 9 * cw + 2;
  endfunction

  function automatic int cfg_width(input int cw);
    return (cw - 1 > EPS_W) ? cw - 1 : EPS_W;
  endfunction
endpackage
`default_nettype wire

>>> hdl/brc_front.sv
// Front end: configuration registers, bounding overlap tests and floor case classification.
`default_nettype none
module brc_front #(
  parameter int CW = brc_pkg::COORD_WIDTH_DEF,
  parameter int FB = brc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  input  wire logic [brc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [brc_pkg::cfg_width(CW)-1:0]    cfg_data,
  input  wire logic                                 cmd,
  input  wire logic signed [CW-1:0]                 rel_x,
  input  wire logic signed [CW-1:0]                 rel_y,
  input  wire logic signed [CW-1:0]                 rel_z,
  input  wire logic [CW-2:0]                        half_x,
  input  wire logic [CW-2:0]                        half_y,
  input  wire logic [CW-2:0]                        half_z,
  input  wire logic signed [CW-1:0]                 ramp_length,
  input  wire logic signed [CW-1:0]                 ramp_height,
  input  wire logic [CW-2:0]                        ramp_half_width,
  input  wire logic                                 box_static,
  output logic [brc_pkg::item_bits(CW)-1:0]         item,
  output logic [brc_pkg::EPS_W-1:0]                 eps
);
  import brc_pkg::*;

  localparam int HW = CW - 1;
  localparam int EW = CW + 2;

  typedef struct packed {
    logic                 cmd;
    logic                 go;
    logic                 fl_hit;
    logic [HW-1:0]        fl_pen;
    logic signed [CW-1:0] fl_cy;
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
    logic signed [CW-1:0] rz;
    logic [HW-1:0]        hx;
    logic [HW-1:0]        hy;
    logic [CW-1:0]        ah;
    logic [CW-1:0]        al;
    logic                 hpos;
    logic                 lneg;
  } item_t;

  function automatic logic [CW-1:0] sat_s(input logic [EW-1:0] v);
    logic [CW-1:0] r;
    if (v[EW-1:CW-1] == '0 || v[EW-1:CW-1] == '1) r = v[CW-1:0];
    else if (v[EW-1]) r = {1'b1, {(CW-1){1'b0}}};
    else r = {1'b0, {(CW-1){1'b1}}};
    return r;
  endfunction

  logic [EPS_W-1:0] epsilon;
  logic [HW-1:0]    floor_min_half_xz;
  logic [HW-1:0]    floor_max_half_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon           <= EPS_W'(EPS_RESET);
      floor_min_half_xz <= HW'(FLOOR_MIN_UNITS) << FB;
      floor_max_half_y  <= HW'(FLOOR_MAX_UNITS) << FB;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EPSILON:   epsilon <= cfg_data[EPS_W-1:0];
        REG_FLOOR_MIN: floor_min_half_xz <= cfg_data[HW-1:0];
        REG_FLOOR_MAX: floor_max_half_y <= cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [EW-1:0] rxe, rye, rze, hxe, hye, hze, wze, le, he;
  logic signed [EW-1:0] xmin, xmax, ymin, ymax, top, fpen;
  logic                 ox, oy, oz, fsel, len_ok;
  logic [CW-1:0]        ah, al;
  item_t                it;

  assign rxe = {{2{rel_x[CW-1]}}, rel_x};
  assign rye = {{2{rel_y[CW-1]}}, rel_y};
  assign rze = {{2{rel_z[CW-1]}}, rel_z};
  assign le  = {{2{ramp_length[CW-1]}}, ramp_length};
  assign he  = {{2{ramp_height[CW-1]}}, ramp_height};
  assign hxe = {3'b000, half_x};
  assign hye = {3'b000, half_y};
  assign hze = {3'b000, half_z};
  assign wze = {3'b000, ramp_half_width};

  assign xmin = le[EW-1] ? le : '0;
  assign xmax = le[EW-1] ? '0 : le;
  assign ymin = he[EW-1] ? he : '0;
  assign ymax = he[EW-1] ? '0 : he;

  assign ox = (rxe + hxe >= xmin) && (xmax >= rxe - hxe);
  assign oy = (rye + hye >= ymin) && (ymax >= rye - hye);
  assign oz = (rze + hze >= -wze) && (wze >= rze - hze);

  assign top  = rye + hye;
  assign fpen = top - ymin;

  assign fsel = cmd && box_static && (half_x >= floor_min_half_xz) &&
                (half_z >= floor_min_half_xz) && (half_y <= floor_max_half_y);

  assign al = ramp_length[CW-1] ? CW'(-ramp_length) : ramp_length;
  assign ah = ramp_height[CW-1] ? CW'(-ramp_height) : ramp_height;
  assign len_ok = al > CW'(epsilon);

  always_comb begin
    it.cmd    = cmd;
    it.go     = !fsel && len_ok && ox && oy && oz;
    it.fl_hit = fsel && ox && oy && oz && (fpen > 0);
    it.fl_pen = (|fpen[EW-1:HW]) ? {HW{1'b1}} : fpen[HW-1:0];
    it.fl_cy  = sat_s(top);
    it.rx     = rel_x;
    it.ry     = rel_y;
    it.rz     = rel_z;
    it.hx     = half_x;
    it.hy     = half_y;
    it.ah     = ah;
    it.al     = al;
    it.hpos   = !ramp_height[CW-1] && (ramp_height != '0);
    it.lneg   = ramp_length[CW-1];
  end

  assign item = it;
  assign eps  = epsilon;
endmodule
`default_nettype wire

>>> hdl/brc_queue.sv
// Short item queue between the front end and the arithmetic pipeline.
`default_nettype none
module brc_queue #(
  parameter int W     = brc_pkg::item_bits(brc_pkg::COORD_WIDTH_DEF),
  parameter int DEPTH = brc_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty,
  output logic              full
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count;
  logic          do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign empty   = count == '0;
  assign full    = count == NW'(DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  assign pop_data = slots[rd_ptr];
endmodule
`default_nettype wire

>>> hdl/brc_back.sv
// Back end: pipelined root, normal division, projection, penetration and contact point.
`default_nettype none
module brc_back #(
  parameter int CW = brc_pkg::COORD_WIDTH_DEF,
  parameter int FB = brc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [brc_pkg::item_bits(CW)-1:0] in_item,
  input  wire logic [brc_pkg::EPS_W-1:0]     eps,
  output logic                               done,
  output logic                               hit,
  output logic                               box_first,
  output logic signed [FB+1:0]               normal_x,
  output logic signed [FB+1:0]               normal_y,
  output logic [CW-2:0]                      penetration,
  output logic signed [CW-1:0]               contact_x,
  output logic signed [CW-1:0]               contact_y,
  output logic signed [CW-1:0]               contact_z
);
  import brc_pkg::*;

  localparam int HW = CW - 1;
  localparam int NW = FB + 2;
  localparam int PW = CW + NW;
  localparam int QW = FB + CW;
  localparam int JW = QW + 1;
  localparam int DW = CW + FB + 3;
  localparam int TW = DW - FB;
  localparam int MW = FB + 1 + TW;
  localparam int XW = CW + 3;

  typedef struct packed {
    logic                 cmd;
    logic                 go;
    logic                 fl_hit;
    logic [HW-1:0]        fl_pen;
    logic signed [CW-1:0] fl_cy;
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
    logic signed [CW-1:0] rz;
    logic [HW-1:0]        hx;
    logic [HW-1:0]        hy;
    logic [CW-1:0]        ah;
    logic [CW-1:0]        al;
    logic                 hpos;
    logic                 lneg;
  } item_t;

  function automatic logic [CW-1:0] sat_s(input logic [XW-1:0] v);
    logic [CW-1:0] r;
    if (v[XW-1:CW-1] == '0 || v[XW-1:CW-1] == '1) r = v[CW-1:0];
    else if (v[XW-1]) r = {1'b1, {(CW-1){1'b0}}};
    else r = {1'b0, {(CW-1){1'b1}}};
    return r;
  endfunction

  // squares and their sum
  logic            a_v, b_v;
  item_t           a_it, b_it;
  logic [2*CW-1:0] a_sqh, a_sql, b_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else begin
      a_v <= in_valid;
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    a_it  <= in_item;
    a_sqh <= in_item[2*CW+1 -: CW] * in_item[2*CW+1 -: CW];
    a_sql <= in_item[CW+1 -: CW] * in_item[CW+1 -: CW];
    b_it  <= a_it;
    b_rad <= a_sqh + a_sql;
  end

  // integer root, two radicand bits per stage
  logic            sq_v    [CW+1];
  item_t           sq_it   [CW+1];
  logic [2*CW-1:0] sq_rad  [CW+1];
  logic [CW+1:0]   sq_rem  [CW+1];
  logic [CW-1:0]   sq_root [CW+1];

  assign sq_v[0]    = b_v;
  assign sq_it[0]   = b_it;
  assign sq_rad[0]  = b_rad;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < CW; k++) begin : g_root
    logic [CW+3:0] rsh, trial;
    logic          ge;
    assign rsh   = {sq_rem[k], sq_rad[k][2*CW-1 -: 2]};
    assign trial = {2'b00, sq_root[k], 2'b01};
    assign ge    = rsh >= trial;

    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else sq_v[k+1] <= sq_v[k];
    end

    always_ff @(posedge clk) begin
      sq_it[k+1]   <= sq_it[k];
      sq_rad[k+1]  <= sq_rad[k] << 2;
      sq_rem[k+1]  <= ge ? (CW+2)'(rsh - trial) : (CW+2)'(rsh);
      sq_root[k+1] <= {sq_root[k][CW-2:0], ge};
    end
  end

  // restoring division of both components by the magnitude
  logic          dv_v   [FB+2];
  item_t         dv_it  [FB+2];
  logic          dv_gok [FB+2];
  logic [CW-1:0] dv_mag [FB+2];
  logic [CW-1:0] dv_rh  [FB+2];
  logic [CW-1:0] dv_rl  [FB+2];
  logic [FB:0]   dv_qh  [FB+2];
  logic [FB:0]   dv_ql  [FB+2];

  assign dv_v[0]   = sq_v[CW];
  assign dv_it[0]  = sq_it[CW];
  assign dv_gok[0] = sq_root[CW] > CW'(eps);
  assign dv_mag[0] = sq_root[CW];
  assign dv_rh[0]  = {1'b0, sq_it[CW].ah[CW-1:1]};
  assign dv_rl[0]  = {1'b0, sq_it[CW].al[CW-1:1]};
  assign dv_qh[0]  = '0;
  assign dv_ql[0]  = '0;

  for (genvar k = 0; k <= FB; k++) begin : g_div
    logic [CW:0] rh, rl;
    logic        geh, gel;
    assign rh  = {dv_rh[k], (k == 0) ? dv_it[k].ah[0] : 1'b0};
    assign rl  = {dv_rl[k], (k == 0) ? dv_it[k].al[0] : 1'b0};
    assign geh = rh >= {1'b0, dv_mag[k]};
    assign gel = rl >= {1'b0, dv_mag[k]};

    always_ff @(posedge clk) begin
      if (rst) dv_v[k+1] <= 1'b0;
      else dv_v[k+1] <= dv_v[k];
    end

    always_ff @(posedge clk) begin
      dv_it[k+1]  <= dv_it[k];
      dv_gok[k+1] <= dv_gok[k];
      dv_mag[k+1] <= dv_mag[k];
      dv_rh[k+1]  <= geh ? CW'(rh - {1'b0, dv_mag[k]}) : CW'(rh);
      dv_rl[k+1]  <= gel ? CW'(rl - {1'b0, dv_mag[k]}) : CW'(rl);
      dv_qh[k+1]  <= {dv_qh[k][FB-1:0], geh};
      dv_ql[k+1]  <= {dv_ql[k][FB-1:0], gel};
    end
  end

  // normal, dot product, projection, flip, depth, contact point
  logic                 e0_v, e1_v, e2_v, e3_v, e4_v, e5_v;
  item_t                e0_it, e1_it, e2_it, e3_it, e4_it, e5_it;
  logic                 e0_gok, e1_gok, e2_gok, e3_gok;
  logic [FB:0]          e0_mx, e0_my, e1_mx, e1_my, e2_mx, e2_my, e3_mx, e3_my;
  logic signed [NW-1:0] e0_nx, e0_ny, e1_nx, e1_ny, e2_nx, e2_ny, e3_nx, e3_ny;
  logic signed [NW-1:0] e4_nx, e4_ny, e5_nx, e5_ny;
  logic signed [PW-1:0] e1_p1, e1_p2;
  logic [QW-1:0]        e1_q1, e1_q2;
  logic signed [DW-1:0] e2_dot;
  logic [JW-1:0]        e2_proj, e3_proj;
  logic [DW-1:0]        e3_adot, e4_diff;
  logic                 e4_hit, e5_hit;
  logic [HW-1:0]        e4_pen, e5_pen;
  logic [MW-1:0]        e4_px, e4_py;
  logic signed [XW-1:0] e5_sx, e5_sy;
  logic [XW-1:0]        mag_x, mag_y;
  logic signed [XW-1:0] cx_full, cy_full;

  assign e4_diff = DW'(e3_proj) - e3_adot;
  assign mag_x   = {1'b0, e4_px[FB+CW+1:FB]};
  assign mag_y   = {1'b0, e4_py[FB+CW+1:FB]};
  assign cx_full = {{3{e5_it.rx[CW-1]}}, e5_it.rx} - e5_sx;
  assign cy_full = {{3{e5_it.ry[CW-1]}}, e5_it.ry} - e5_sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      e0_v <= 1'b0;
      e1_v <= 1'b0;
      e2_v <= 1'b0;
      e3_v <= 1'b0;
      e4_v <= 1'b0;
      e5_v <= 1'b0;
      done <= 1'b0;
    end else begin
      e0_v <= dv_v[FB+1];
      e1_v <= e0_v;
      e2_v <= e1_v;
      e3_v <= e2_v;
      e4_v <= e3_v;
      e5_v <= e4_v;
      done <= e5_v;
    end
  end

  always_ff @(posedge clk) begin
    e0_it  <= dv_it[FB+1];
    e0_gok <= dv_gok[FB+1];
    e0_mx  <= dv_qh[FB+1];
    e0_my  <= dv_ql[FB+1];
    e0_nx  <= dv_it[FB+1].hpos ? -$signed({1'b0, dv_qh[FB+1]}) : $signed({1'b0, dv_qh[FB+1]});
    e0_ny  <= dv_it[FB+1].lneg ? -$signed({1'b0, dv_ql[FB+1]}) : $signed({1'b0, dv_ql[FB+1]});

    e1_it  <= e0_it;
    e1_gok <= e0_gok;
    e1_mx  <= e0_mx;
    e1_my  <= e0_my;
    e1_nx  <= e0_nx;
    e1_ny  <= e0_ny;
    e1_p1  <= $signed(e0_it.rx) * e0_nx;
    e1_p2  <= $signed(e0_it.ry) * e0_ny;
    e1_q1  <= e0_mx * e0_it.hx;
    e1_q2  <= e0_my * e0_it.hy;

    e2_it   <= e1_it;
    e2_gok  <= e1_gok;
    e2_mx   <= e1_mx;
    e2_my   <= e1_my;
    e2_nx   <= e1_nx;
    e2_ny   <= e1_ny;
    e2_dot  <= DW'(e1_p1) + DW'(e1_p2);
    e2_proj <= JW'(e1_q1) + JW'(e1_q2);

    e3_it   <= e2_it;
    e3_gok  <= e2_gok;
    e3_mx   <= e2_mx;
    e3_my   <= e2_my;
    e3_proj <= e2_proj;
    e3_adot <= e2_dot[DW-1] ? DW'(-e2_dot) : DW'(e2_dot);
    e3_nx   <= e2_dot[DW-1] ? -e2_nx : e2_nx;
    e3_ny   <= e2_dot[DW-1] ? -e2_ny : e2_ny;

    e4_it  <= e3_it;
    e4_nx  <= e3_nx;
    e4_ny  <= e3_ny;
    e4_hit <= e3_gok && (DW'(e3_proj) > e3_adot);
    e4_pen <= (|e4_diff[DW-1:FB+HW]) ? {HW{1'b1}} : e4_diff[FB+HW-1:FB];
    e4_px  <= e3_mx * e3_adot[DW-1:FB];
    e4_py  <= e3_my * e3_adot[DW-1:FB];

    e5_it  <= e4_it;
    e5_hit <= e4_hit;
    e5_pen <= e4_pen;
    e5_nx  <= e4_it.cmd ? -e4_nx : e4_nx;
    e5_ny  <= e4_it.cmd ? -e4_ny : e4_ny;
    e5_sx  <= e4_nx[NW-1] ? -$signed(mag_x) : $signed(mag_x);
    e5_sy  <= e4_ny[NW-1] ? -$signed(mag_y) : $signed(mag_y);

    if (e5_it.fl_hit) begin
      hit         <= 1'b1;
      box_first   <= 1'b1;
      normal_x    <= '0;
      normal_y    <= NW'(1) << FB;
      penetration <= e5_it.fl_pen;
      contact_x   <= '0;
      contact_y   <= e5_it.fl_cy;
      contact_z   <= '0;
    end else if (e5_it.go && e5_hit) begin
      hit         <= 1'b1;
      box_first   <= e5_it.cmd;
      normal_x    <= e5_nx;
      normal_y    <= e5_ny;
      penetration <= e5_pen;
      contact_x   <= sat_s(cx_full);
      contact_y   <= sat_s(cy_full);
      contact_z   <= e5_it.rz;
    end else begin
      hit         <= 1'b0;
      box_first   <= 1'b0;
      normal_x    <= '0;
      normal_y    <= '0;
      penetration <= '0;
      contact_x   <= '0;
      contact_y   <= '0;
      contact_z   <= '0;
    end
  end
endmodule
`default_nettype wire

>>> hdl/box_ramp_contact_unit.sv
// Top level of the box/ramp contact unit: front end, item queue and arithmetic pipeline.
//
//  channel   signals                           beat taken when
//  -------   -------------------------------   ---------------------------
//  input     start, busy, item fields          start && !busy
//  result    done, result fields               done (one cycle, no stall)
//  config    cfg_valid, cfg_ready, index/data  cfg_valid && cfg_ready
//
// One pair per cycle while busy is low; the root (one result bit per stage) and the two dividers
// (one quotient bit per stage) are fully pipelined.
// rst is synchronous; it clears the pipeline valids and the queue and reloads the config defaults.
// busy only rises if the queue fills; the pipeline drains every cycle.
`default_nettype none
module box_ramp_contact_unit #(
  parameter int COORD_WIDTH = brc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = brc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       start,
  output logic                                            busy,
  input  wire logic                                       cmd,
  input  wire logic signed [COORD_WIDTH-1:0]              rel_x,
  input  wire logic signed [COORD_WIDTH-1:0]              rel_y,
  input  wire logic signed [COORD_WIDTH-1:0]              rel_z,
  input  wire logic [COORD_WIDTH-2:0]                     half_x,
  input  wire logic [COORD_WIDTH-2:0]                     half_y,
  input  wire logic [COORD_WIDTH-2:0]                     half_z,
  input  wire logic signed [COORD_WIDTH-1:0]              ramp_length,
  input  wire logic signed [COORD_WIDTH-1:0]              ramp_height,
  input  wire logic [COORD_WIDTH-2:0]                     ramp_half_width,
  input  wire logic                                       box_static,
  output logic                                            done,
  output logic                                            hit,
  output logic                                            box_first,
  output logic signed [FRAC_BITS+1:0]                     normal_x,
  output logic signed [FRAC_BITS+1:0]                     normal_y,
  output logic [COORD_WIDTH-2:0]                          penetration,
  output logic signed [COORD_WIDTH-1:0]                   contact_x,
  output logic signed [COORD_WIDTH-1:0]                   contact_y,
  output logic signed [COORD_WIDTH-1:0]                   contact_z,
  input  wire logic                                       cfg_valid,
  output logic                                            cfg_ready,
  input  wire logic [brc_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  wire logic [brc_pkg::cfg_width(COORD_WIDTH)-1:0] cfg_data
);
  import brc_pkg::*;

  localparam int IW = item_bits(COORD_WIDTH);

  logic [IW-1:0]    f_item, q_item;
  logic [EPS_W-1:0] eps;
  logic             q_empty, q_full;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;

  brc_front #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .rel_x           (rel_x),
    .rel_y           (rel_y),
    .rel_z           (rel_z),
    .half_x          (half_x),
    .half_y          (half_y),
    .half_z          (half_z),
    .ramp_length     (ramp_length),
    .ramp_height     (ramp_height),
    .ramp_half_width (ramp_half_width),
    .box_static      (box_static),
    .item            (f_item),
    .eps             (eps)
  );

  brc_queue #(.W(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (start && !q_full),
    .push_data (f_item),
    .pop       (!q_empty),
    .pop_data  (q_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  brc_back #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (!q_empty),
    .in_item     (q_item),
    .eps         (eps),
    .done        (done),
    .hit         (hit),
    .box_first   (box_first),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .penetration (penetration),
    .contact_x   (contact_x),
    .contact_y   (contact_y),
    .contact_z   (contact_z)
  );

`ifndef ASSERT_OFF
  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (!box_first && normal_x == '0 && normal_y == '0 &&
      penetration == '0 && contact_x == '0 && contact_y == '0 && contact_z == '0))
    else $error("miss result carries nonzero fields");
  a_queue_drains: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("item queue filled although the pipeline never stalls");
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result beat straight after reset");
  a_unit_normal: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (normal_y <= $signed((FRAC_BITS+2)'(1) << FRAC_BITS) &&
      normal_y >= -$signed((FRAC_BITS+2)'(1) << FRAC_BITS)))
    else $error("normal component beyond one");
`endif
endmodule
`default_nettype wire
